>>> src/bmpca_pkg.sv
// ----------------------------------------------------------------------------
// bmpca_pkg
// Shared constants, types and commands of the banded minimum-cost path
// accumulator.
// ----------------------------------------------------------------------------
package bmpca_pkg;

  localparam int unsigned IMAGE_HEIGHT   = 1024;
  localparam int unsigned STEP_LIMIT     = 15;
  localparam int unsigned COST_W         = 32;
  localparam int unsigned PIX_W          = 24;
  localparam int unsigned ROW_W          = 10;
  localparam int unsigned STEP_W         = 4;
  localparam int unsigned ADDR_W         = $clog2(IMAGE_HEIGHT);
  localparam int unsigned LIMIT_W        = $clog2(STEP_LIMIT + 1);
  localparam int unsigned EPOCH_W        = ADDR_W + 1;
  localparam int unsigned IN_TDATA_W     = 56;
  localparam int unsigned OUT_TDATA_W    = 48;

  localparam logic [STEP_W-1:0] MAX_STEP_RESET = STEP_W'(3);
  localparam logic [LIMIT_W-1:0] STEP_LIMIT_C  = LIMIT_W'(STEP_LIMIT);
  localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
  localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_SUM,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic idle;
    logic accept;
    logic setup;
    logic scan_rd;
    logic sum;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic window_empty;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

>>> src/banded_min_path_cost_accumulator_core.sv
// Each pixel is taken in idle, then passes setup, a window scan of the n previous-column
// rows in the window (up to 2 * max_step + 1) with a drain, the sum and the write; scan
// and drain are skipped when none is read. A new pixel is not taken before the last is written;
// the window scan walks the single read port of the cost store one row per cycle.
// A result held by the receiver stalls the sequencer and the input for as long as it waits.
// Reset: asynchronous, clears control, the previous band and max_step (to 3); no store clear.
// ----------------------------------------------------------------------------
// banded_min_path_cost_accumulator_core
// Streams column-major cost pixels and returns the banded minimum accumulated
// path cost of each pixel.
// ----------------------------------------------------------------------------
module banded_min_path_cost_accumulator_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bmpca_pkg::STEP_W-1:0]          cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pixel_cost[23:0], row_index[33:24], band_top[43:34], band_bottom[53:44], zero fill
  input  logic [bmpca_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // first_column
  input  logic                                  s_axis_tuser,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // path_cost[31:0], out_row[41:32], zero fill
  output logic [bmpca_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                  m_axis_tlast
);

  bmpca_pkg::cmd_t                     cmd;
  bmpca_pkg::status_t                  status;
  logic signed [bmpca_pkg::COST_W-1:0] path_cost;
  logic [bmpca_pkg::ROW_W-1:0]         out_row;

  bmpca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bmpca_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pixel_cost_i     (s_axis_tdata[23:0]),
    .row_index_i      (s_axis_tdata[33:24]),
    .band_top_i       (s_axis_tdata[43:34]),
    .band_bottom_i    (s_axis_tdata[53:44]),
    .first_column_i   (s_axis_tuser),
    .column_end_i     (s_axis_tlast),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .path_cost_o      (path_cost),
    .out_row_o        (out_row),
    .out_column_end_o (m_axis_tlast)
  );

  assign s_axis_tready = cmd.idle;
  assign m_axis_tdata  = {6'b000000, out_row, path_cost};

endmodule

>>> src/bmpca_ctrl.sv
// ----------------------------------------------------------------------------
// bmpca_ctrl
// Sequencer that steps one pixel through setup, window scan and drain (both skipped
// when the window is empty), sum and write-back.
// ----------------------------------------------------------------------------
module bmpca_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  bmpca_pkg::status_t status_i,
  output bmpca_pkg::cmd_t    cmd_o
);

  bmpca_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmpca_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      bmpca_pkg::ST_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = bmpca_pkg::ST_SETUP;
        end
      end
      bmpca_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = status_i.window_empty ? bmpca_pkg::ST_SUM : bmpca_pkg::ST_SCAN;
      end
      bmpca_pkg::ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = bmpca_pkg::ST_DRAIN;
        end
      end
      bmpca_pkg::ST_DRAIN: begin
        state_d = bmpca_pkg::ST_SUM;
      end
      bmpca_pkg::ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = bmpca_pkg::ST_WRITE;
      end
      bmpca_pkg::ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = bmpca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bmpca_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/bmpca_datapath.sv
// ----------------------------------------------------------------------------
// bmpca_datapath
// Column cost stores, window scan with running minimum, saturating sum and
// output register.
// ----------------------------------------------------------------------------
module bmpca_datapath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  bmpca_pkg::cmd_t                         cmd_i,
  output bmpca_pkg::status_t                      status_o,
  input  logic                                    cfg_we_i,
  input  logic [bmpca_pkg::STEP_W-1:0]            cfg_wdata_i,
  input  logic signed [bmpca_pkg::PIX_W-1:0]      pixel_cost_i,
  input  logic [bmpca_pkg::ROW_W-1:0]             row_index_i,
  input  logic [bmpca_pkg::ROW_W-1:0]             band_top_i,
  input  logic [bmpca_pkg::ROW_W-1:0]             band_bottom_i,
  input  logic                                    first_column_i,
  input  logic                                    column_end_i,
  input  logic                                    out_ready_i,
  output logic                                    out_valid_o,
  output logic signed [bmpca_pkg::COST_W-1:0]     path_cost_o,
  output logic [bmpca_pkg::ROW_W-1:0]             out_row_o,
  output logic                                    out_column_end_o
);

  localparam int unsigned WORD_W = bmpca_pkg::EPOCH_W + bmpca_pkg::COST_W;
  localparam int unsigned SUM_W  = bmpca_pkg::COST_W + 2;
  localparam int unsigned WIN_W  = bmpca_pkg::ROW_W + 2;

  logic signed [bmpca_pkg::PIX_W-1:0]  cost_q;
  logic [bmpca_pkg::ROW_W-1:0]         row_q, top_q, bot_q;
  logic                                first_q, last_q;
  logic [bmpca_pkg::STEP_W-1:0]        max_step_q;
  logic [bmpca_pkg::ROW_W-1:0]         ptop_q, pbot_q;
  logic [bmpca_pkg::EPOCH_W-1:0]       epoch_q;
  logic [bmpca_pkg::ADDR_W-1:0]        scrub_ptr_q;
  logic [bmpca_pkg::ADDR_W-1:0]        k_q, hi_q;
  logic                                rd_vld_q;
  logic signed [bmpca_pkg::COST_W-1:0] best_q, res_q;
  logic                                out_valid_q;
  logic signed [bmpca_pkg::COST_W-1:0] out_cost_q;
  logic [bmpca_pkg::ROW_W-1:0]         out_row_q;
  logic                                out_last_q;

  logic [WORD_W-1:0]                   cur_mem [bmpca_pkg::IMAGE_HEIGHT];
  logic [bmpca_pkg::COST_W-1:0]        prev_mem [bmpca_pkg::IMAGE_HEIGHT];
  logic [WORD_W-1:0]                   cur_rdata_q;
  logic [bmpca_pkg::COST_W-1:0]        prev_rdata_q;

  logic                                cur_rd_en, cur_we, prev_we;
  logic [bmpca_pkg::ADDR_W-1:0]        cur_rd_addr, cur_wr_addr;
  logic [WORD_W-1:0]                   cur_wdata;
  logic [bmpca_pkg::EPOCH_W-1:0]       cur_tag;
  logic signed [bmpca_pkg::COST_W-1:0] cur_val, cand;
  logic                                scrub_stale;

  logic [bmpca_pkg::LIMIT_W-1:0]       step;
  logic signed [WIN_W-1:0]             lo_raw, lo_win, hi_raw, hi_win;
  logic                                in_band, empty;
  logic signed [SUM_W-1:0]             sum_full;
  logic signed [bmpca_pkg::COST_W-1:0] sum_sat;

  assign cur_tag     = cur_rdata_q[bmpca_pkg::COST_W +: bmpca_pkg::EPOCH_W];
  assign cur_val     = cur_rdata_q[bmpca_pkg::COST_W-1:0];
  assign cand        = (cur_tag == epoch_q) ? prev_rdata_q : cur_val;
  assign scrub_stale = (cur_tag != epoch_q);

  // A row whose tag matches the epoch was rewritten in this column, so its
  // previous-column value lives in the second store.
  always_comb begin
    cur_rd_en   = cmd_i.idle | cmd_i.scan_rd | cmd_i.sum;
    cur_rd_addr = scrub_ptr_q;
    if (cmd_i.scan_rd) begin
      cur_rd_addr = k_q;
    end else if (cmd_i.sum) begin
      cur_rd_addr = row_q;
    end
    cur_we      = 1'b0;
    cur_wr_addr = row_q;
    cur_wdata   = {epoch_q, res_q};
    prev_we     = cmd_i.write & scrub_stale;
    if (cmd_i.write) begin
      cur_we = 1'b1;
    end else if (cmd_i.setup && scrub_stale) begin
      cur_we      = 1'b1;
      cur_wr_addr = scrub_ptr_q;
      cur_wdata   = {epoch_q - 1'b1, cur_val};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_rd_en) begin
      cur_rdata_q <= cur_mem[cur_rd_addr];
    end
    if (cur_we) begin
      cur_mem[cur_wr_addr] <= cur_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      prev_rdata_q <= prev_mem[k_q];
    end
    if (prev_we) begin
      prev_mem[row_q] <= cur_val;
    end
  end

  always_comb begin
    step = (max_step_q > bmpca_pkg::STEP_W'(bmpca_pkg::STEP_LIMIT_C))
         ? bmpca_pkg::STEP_LIMIT_C : bmpca_pkg::LIMIT_W'(max_step_q);
    in_band = !first_q && (row_q >= top_q) && (row_q <= bot_q);
    lo_raw  = $signed({2'b00, row_q}) - $signed(WIN_W'(step));
    lo_win  = (lo_raw < $signed({2'b00, ptop_q})) ? $signed({2'b00, ptop_q}) : lo_raw;
    hi_raw  = $signed({2'b00, row_q}) + $signed(WIN_W'(step));
    hi_win  = (hi_raw > $signed({2'b00, pbot_q})) ? $signed({2'b00, pbot_q}) : hi_raw;
    empty   = !in_band || (lo_win > hi_win);
    sum_full = SUM_W'(cost_q) + SUM_W'(best_q);
    if (sum_full > SUM_W'(bmpca_pkg::COST_MAX)) begin
      sum_sat = bmpca_pkg::COST_MAX;
    end else if (sum_full < SUM_W'(bmpca_pkg::COST_MIN)) begin
      sum_sat = bmpca_pkg::COST_MIN;
    end else begin
      sum_sat = sum_full[bmpca_pkg::COST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cost_q  <= pixel_cost_i;
      row_q   <= row_index_i;
      top_q   <= band_top_i;
      bot_q   <= band_bottom_i;
      first_q <= first_column_i;
      last_q  <= column_end_i;
    end
    if (cmd_i.setup) begin
      k_q    <= lo_win[bmpca_pkg::ADDR_W-1:0];
      hi_q   <= hi_win[bmpca_pkg::ADDR_W-1:0];
      best_q <= bmpca_pkg::COST_MAX;
    end else if (rd_vld_q && (cand < best_q)) begin
      best_q <= cand;
    end
    if (cmd_i.scan_rd) begin
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.sum) begin
      res_q <= in_band ? sum_sat : bmpca_pkg::COST_W'(cost_q);
    end
    if (cmd_i.write) begin
      out_cost_q <= res_q;
      out_row_q  <= row_q;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q  <= bmpca_pkg::MAX_STEP_RESET;
      ptop_q      <= '0;
      pbot_q      <= '0;
      epoch_q     <= '0;
      scrub_ptr_q <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cfg_we_i) begin
        max_step_q <= cfg_wdata_i;
      end
      if (cmd_i.setup) begin
        scrub_ptr_q <= scrub_ptr_q + 1'b1;
      end
      if (cmd_i.write) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          epoch_q <= epoch_q + 1'b1;
          ptop_q  <= top_q;
          pbot_q  <= bot_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.window_empty = empty;
  assign status_o.scan_last    = (k_q == hi_q);
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign path_cost_o      = out_cost_q;
  assign out_row_o        = out_row_q;
  assign out_column_end_o = out_last_q;

`ifndef SYNTH
  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> (k_q <= hi_q))
    else $error("window scan ran past its upper row");

  a_write_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> (!out_valid_q || out_ready_i))
    else $error("result written over an untaken result");

  a_epoch_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.write && last_q) |=> (epoch_q == bmpca_pkg::EPOCH_W'($past(epoch_q) + 1'b1)))
    else $error("epoch did not advance at column end");
`endif

endmodule
